// ----- design/format_string_formatter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the format string formatter
// Immediate-consequence and next-cycle property wrappers on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef FORMAT_STRING_FORMATTER_TOP_ASSERT_SVH
`define FORMAT_STRING_FORMATTER_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define FSF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSF_ASSERT(lbl, ante, cons, msg)
`define FSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/fsf_pkg.sv -----
// ----------------------------------------------------------------------------
// fsf_pkg
// Shared types and character codes of the format string formatter.
// ----------------------------------------------------------------------------
package fsf_pkg;

  localparam int unsigned WIDTH_CAP_DEF = 31;
  localparam int unsigned FW_W          = 5;
  localparam int unsigned DEC_DIGITS    = 10;

  typedef enum logic [1:0] {
    ACT_FMT  = 2'd0,
    ACT_STR  = 2'd1,
    ACT_END  = 2'd2,
    ACT_NONE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_ZERO  = 2'd1,
    PK_SPACE = 2'd2,
    PK_AFTER = 2'd3
  } pad_e;

  typedef enum logic [2:0] {
    K_CHAR = 3'd0,
    K_PCT2 = 3'd1,
    K_DEC  = 3'd2,
    K_HEX  = 3'd3,
    K_PTR  = 3'd4,
    K_END  = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       ch;
    logic             cr;
    logic             neg;
    logic [31:0]      val;
    pad_e             pk;
    logic [FW_W-1:0]  w;
  } cmd_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd87;

endpackage

// ----- design/fsf_front.sv -----
// ----------------------------------------------------------------------------
// fsf_front
// Parses format beats, tracks conversion flags and width, issues commands.
// ----------------------------------------------------------------------------
module fsf_front #(
  parameter int unsigned WidthCap = fsf_pkg::WIDTH_CAP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          unix_i,
  input  logic                          valid_i,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    ch_i,
  input  logic [31:0]                   arg_i,
  input  logic                          full_i,
  output logic                          stall_o,
  output logic                          push_o,
  output fsf_pkg::cmd_t                 cmd_o
);

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_CONV,
    MODE_STR
  } mode_e;

  localparam logic [8:0] CapW = 9'(WidthCap);

  mode_e                     mode_q, mode_d, mode_eff;
  fsf_pkg::pad_e             pk_q, pk_d;
  logic                      fw_set_q, fw_set_d;
  logic [fsf_pkg::FW_W-1:0]  fw_q, fw_d;
  logic                      acc;
  logic [8:0]                fw_acc;
  logic [3:0]                dig;
  logic signed [6:0]         wi;
  logic                      is_digit;

  assign acc     = valid_i & ~full_i;
  assign stall_o = full_i;

  assign is_digit = (ch_i >= fsf_pkg::CH_0) && (ch_i <= fsf_pkg::CH_9);
  assign dig      = 4'(ch_i - fsf_pkg::CH_0);
  assign fw_acc   = fw_set_q ? (9'(fw_q) * 9'd10 + 9'(dig)) : 9'(dig);
  assign wi       = (fw_set_q ? $signed({2'b00, fw_q}) : -7'sd1)
                    - (arg_i[31] ? 7'sd1 : 7'sd0);

  // classify the beat and update parse state
  always_comb begin
    mode_d   = mode_q;
    pk_d     = pk_q;
    fw_set_d = fw_set_q;
    fw_d     = fw_q;
    mode_eff = (mode_q == MODE_STR) ? MODE_TEXT : mode_q;
    push_o   = 1'b0;
    cmd_o.kind = fsf_pkg::K_CHAR;
    cmd_o.ch   = ch_i;
    cmd_o.cr   = 1'b0;
    cmd_o.neg  = 1'b0;
    cmd_o.val  = arg_i;
    cmd_o.pk   = pk_q;
    cmd_o.w    = fw_set_q ? fw_q : '0;
    if (acc) begin
      case (action_i)
        fsf_pkg::ACT_FMT: begin
          if (ch_i != fsf_pkg::CH_NUL) begin
            mode_d = mode_eff;
            if (mode_eff == MODE_TEXT) begin
              if (ch_i == fsf_pkg::CH_PCT) begin
                mode_d   = MODE_CONV;
                pk_d     = fsf_pkg::PK_NONE;
                fw_set_d = 1'b0;
              end else begin
                push_o   = 1'b1;
                cmd_o.cr = ~unix_i && (ch_i == fsf_pkg::CH_LF);
              end
            end else if (ch_i == fsf_pkg::CH_MINUS) begin
              pk_d = fsf_pkg::PK_AFTER;
            end else if (ch_i == fsf_pkg::CH_0 && !fw_set_q && pk_q == fsf_pkg::PK_NONE) begin
              pk_d = fsf_pkg::PK_ZERO;
            end else if (is_digit) begin
              fw_set_d = 1'b1;
              fw_d     = (fw_acc > CapW) ? CapW[fsf_pkg::FW_W-1:0] : fw_acc[fsf_pkg::FW_W-1:0];
              if (pk_q == fsf_pkg::PK_NONE) pk_d = fsf_pkg::PK_SPACE;
            end else if (ch_i == fsf_pkg::CH_L || ch_i == fsf_pkg::CH_H
                         || ch_i == fsf_pkg::CH_Z) begin
              mode_d = MODE_CONV;
            end else begin
              mode_d = MODE_TEXT;
              push_o = 1'b1;
              if (ch_i == fsf_pkg::CH_D || ch_i == fsf_pkg::CH_I) begin
                cmd_o.kind = fsf_pkg::K_DEC;
                cmd_o.neg  = arg_i[31];
                cmd_o.val  = arg_i[31] ? (32'd0 - arg_i) : arg_i;
                cmd_o.w    = (wi <= 7'sd0) ? 5'd1 : wi[fsf_pkg::FW_W-1:0];
              end else if (ch_i == fsf_pkg::CH_U) begin
                cmd_o.kind = fsf_pkg::K_DEC;
                cmd_o.w    = (fw_set_q && fw_q != '0) ? fw_q : 5'd1;
              end else if (ch_i == fsf_pkg::CH_P) begin
                cmd_o.kind = fsf_pkg::K_PTR;
                cmd_o.pk   = fsf_pkg::PK_ZERO;
                cmd_o.w    = 5'd8;
              end else if (ch_i == fsf_pkg::CH_X || ch_i == fsf_pkg::CH_XU) begin
                cmd_o.kind = fsf_pkg::K_HEX;
              end else if (ch_i == fsf_pkg::CH_S) begin
                mode_d = MODE_STR;
                push_o = 1'b0;
              end else if (ch_i == fsf_pkg::CH_C) begin
                cmd_o.ch = arg_i[7:0];
              end else if (ch_i == fsf_pkg::CH_PCT) begin
                cmd_o.ch = fsf_pkg::CH_PCT;
              end else begin
                cmd_o.kind = fsf_pkg::K_PCT2;
              end
            end
          end
        end
        fsf_pkg::ACT_STR: begin
          if (mode_q == MODE_STR) begin
            if (ch_i == fsf_pkg::CH_NUL) mode_d = MODE_TEXT;
            else push_o = 1'b1;
          end
        end
        fsf_pkg::ACT_END: begin
          push_o     = 1'b1;
          cmd_o.kind = fsf_pkg::K_END;
          mode_d     = MODE_TEXT;
          pk_d       = fsf_pkg::PK_NONE;
          fw_set_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TEXT;
      pk_q     <= fsf_pkg::PK_NONE;
      fw_set_q <= 1'b0;
      fw_q     <= '0;
    end else begin
      mode_q   <= mode_d;
      pk_q     <= pk_d;
      fw_set_q <= fw_set_d;
      fw_q     <= fw_d;
    end
  end

endmodule

// ----- design/fsf_cmdq.sv -----
// ----------------------------------------------------------------------------
// fsf_cmdq
// Two-entry command queue between parser and character generator.
// ----------------------------------------------------------------------------
module fsf_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fsf_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output fsf_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  fsf_pkg::cmd_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = mem_q[rp_q];

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- design/fsf_back.sv -----
// ----------------------------------------------------------------------------
// fsf_back
// Character generator: expands commands into output beats, at most one per cycle
// while out_stall_i is low, with buffer-capacity drop and running length.
// ----------------------------------------------------------------------------
`include "format_string_formatter_top_assert.svh"

module fsf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   buf_size_i,
  input  logic          empty_i,
  input  fsf_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_char_o,
  output logic          out_last_o,
  output logic [15:0]   out_length_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CR, S_PCT, S_LAST, S_MINUS, S_P0, S_PX, S_BCD, S_NUM, S_TRAIL, S_END
  } state_e;

  localparam int unsigned BcdW = 4 * fsf_pkg::DEC_DIGITS;

  state_e                    st_q, st_d;
  logic                      isdec_q, isdec_d, seen_q, seen_d;
  logic [7:0]                ch_q, ch_d;
  fsf_pkg::pad_e             pk_q, pk_d;
  logic [fsf_pkg::FW_W-1:0]  w_q, w_d;
  logic [31:0]               val_q, val_d;
  logic [BcdW-1:0]           bcd_q, bcd_d, bcd_adj;
  logic [4:0]                stp_q, stp_d;
  logic [3:0]                pos_q, pos_d;
  logic [6:0]                cnt_q, cnt_d, target;
  logic [15:0]               kept_q, kept_d, cap;
  logic                      ov_q, ov_d, ol_q, ol_d;
  logic [7:0]                oc_q, oc_d;
  logic [15:0]               olen_q, olen_d;
  logic                      adv, gen, gfin, room, pad_ok;
  logic [3:0]                digit;
  logic [7:0]                gch, dch;

  assign adv    = ~ov_q | ~out_stall_i;
  assign cap    = (buf_size_i == '0) ? '0 : buf_size_i - 16'd1;
  assign room   = kept_q < cap;
  assign target = isdec_q ? {2'b00, w_q} : {1'b0, w_q, 1'b0};
  assign digit  = isdec_q ? bcd_q[{pos_q, 2'b00} +: 4] : val_q[{pos_q[2:0], 2'b00} +: 4];
  assign dch    = (digit > 4'd9) ? ({4'h0, digit} + fsf_pkg::HEX_ALPHA_OFS)
                                 : ({4'h0, digit} + fsf_pkg::CH_0);
  assign pad_ok = ({1'b0, pos_q} + 5'd1 <= w_q)
                  && (pk_q == fsf_pkg::PK_ZERO || pk_q == fsf_pkg::PK_SPACE
                      || (isdec_q && pk_q == fsf_pkg::PK_NONE));

  // add-3 correction of each BCD digit
  always_comb begin
    for (int i = 0; i < fsf_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // sequence the characters of the current command
  always_comb begin
    st_d = st_q; isdec_d = isdec_q; seen_d = seen_q; ch_d = ch_q; pk_d = pk_q;
    w_d = w_q; val_d = val_q; bcd_d = bcd_q; stp_d = stp_q; pos_d = pos_q;
    cnt_d = cnt_q; kept_d = kept_q;
    ov_d = ov_q; oc_d = oc_q; ol_d = ol_q; olen_d = olen_q;
    pop_o = 1'b0; gen = 1'b0; gfin = 1'b0; gch = fsf_pkg::CH_SP;
    if (adv) begin
      ov_d = 1'b0;
      case (st_q)
        S_IDLE: begin
          if (!empty_i) begin
            pop_o   = 1'b1;
            ch_d    = cmd_i.ch;
            pk_d    = cmd_i.pk;
            w_d     = cmd_i.w;
            val_d   = cmd_i.val;
            bcd_d   = '0;
            stp_d   = '0;
            seen_d  = 1'b0;
            cnt_d   = '0;
            isdec_d = cmd_i.kind == fsf_pkg::K_DEC;
            pos_d   = (cmd_i.kind == fsf_pkg::K_DEC) ? 4'd9 : 4'd7;
            case (cmd_i.kind)
              fsf_pkg::K_CHAR: st_d = cmd_i.cr ? S_CR : S_LAST;
              fsf_pkg::K_PCT2: st_d = S_PCT;
              fsf_pkg::K_DEC:  st_d = cmd_i.neg ? S_MINUS : S_BCD;
              fsf_pkg::K_HEX:  st_d = S_NUM;
              fsf_pkg::K_PTR:  st_d = S_P0;
              fsf_pkg::K_END:  st_d = S_END;
              default:         st_d = S_IDLE;
            endcase
          end
        end
        S_CR:    begin gen = 1'b1; gch = fsf_pkg::CH_CR;    st_d = S_LAST;  end
        S_PCT:   begin gen = 1'b1; gch = fsf_pkg::CH_PCT;   st_d = S_LAST;  end
        S_LAST:  begin gen = 1'b1; gch = ch_q; gfin = 1'b1; st_d = S_IDLE;  end
        S_MINUS: begin gen = 1'b1; gch = fsf_pkg::CH_MINUS; st_d = S_BCD;   end
        S_P0:    begin gen = 1'b1; gch = fsf_pkg::CH_0;     st_d = S_PX;    end
        S_PX:    begin gen = 1'b1; gch = fsf_pkg::CH_X;     st_d = S_NUM;   end
        S_BCD: begin
          bcd_d = {bcd_adj[BcdW-2:0], val_q[31]};
          val_d = {val_q[30:0], 1'b0};
          stp_d = stp_q + 5'd1;
          if (stp_q == 5'd31) st_d = S_NUM;
        end
        S_NUM: begin
          if (digit != 4'd0 || seen_q || pos_q == 4'd0) begin
            gen    = 1'b1;
            gch    = dch;
            seen_d = 1'b1;
            cnt_d  = cnt_q + 7'd1;
            if (pos_q == 4'd0) begin
              gfin = !(pk_q == fsf_pkg::PK_AFTER && (cnt_q + 7'd1 < target));
              st_d = gfin ? S_IDLE : S_TRAIL;
            end
          end else if (pad_ok) begin
            gen = 1'b1;
            gch = (pk_q == fsf_pkg::PK_ZERO) ? fsf_pkg::CH_0 : fsf_pkg::CH_SP;
          end
          if (pos_q != 4'd0) pos_d = pos_q - 4'd1;
        end
        S_TRAIL: begin
          gen   = 1'b1;
          gch   = fsf_pkg::CH_SP;
          cnt_d = cnt_q + 7'd1;
          gfin  = cnt_q + 7'd1 >= target;
          if (gfin) st_d = S_IDLE;
        end
        S_END: begin
          ov_d   = 1'b1;
          oc_d   = fsf_pkg::CH_NUL;
          ol_d   = 1'b1;
          olen_d = kept_q;
          kept_d = '0;
          st_d   = S_IDLE;
        end
        default: st_d = S_IDLE;
      endcase
      // keep the beat only while buffer room remains
      if (gen && room) begin
        ov_d   = 1'b1;
        oc_d   = gch;
        ol_d   = gfin || (kept_q + 16'd1 == cap);
        olen_d = kept_q + 16'd1;
        kept_d = kept_q + 16'd1;
      end
    end
  end

  // hold state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      kept_q  <= '0;
      ov_q    <= 1'b0;
      isdec_q <= 1'b0;
      seen_q  <= 1'b0;
      stp_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      st_q    <= st_d;
      kept_q  <= kept_d;
      ov_q    <= ov_d;
      isdec_q <= isdec_d;
      seen_q  <= seen_d;
      stp_q   <= stp_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    pk_q   <= pk_d;
    w_q    <= w_d;
    val_q  <= val_d;
    bcd_q  <= bcd_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    olen_q <= olen_d;
  end

  assign out_valid_o  = ov_q;
  assign out_char_o   = oc_q;
  assign out_last_o   = ol_q;
  assign out_length_o = olen_q;

  `FSF_ASSERT(a_pos_range, st_q == S_NUM, pos_q <= 4'd9, "digit position out of range")
  `FSF_ASSERT_NXT(a_end_clears, adv && st_q == S_END, kept_q == '0, "end did not clear length")
  `FSF_ASSERT(a_trail_after, st_q == S_TRAIL, pk_q == fsf_pkg::PK_AFTER, "trailing pad without '-'")

endmodule

// ----- design/format_string_formatter_top.sv -----
// Timing: text, %c, %%, %p and a '-' sign pass the command queue, the back-end
// state register and the output register; decimal digits follow a binary-to-BCD
// conversion. Throughput: at most one output character per cycle, none while
// out_stall_i holds the output; a new command is popped only once the last one is
// done. Reset: rst_ni asynchronous active low; clears parse state, queue, length,
// buffer_size to 256 and unix_line_ending to 1.
// ----------------------------------------------------------------------------
// format_string_formatter_top
// Minimal printf formatter: parser front end, command queue, character back end.
// ----------------------------------------------------------------------------
module format_string_formatter_top #(
  parameter int unsigned WidthCap = fsf_pkg::WIDTH_CAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  ch_i,
  input  logic [31:0] arg_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        out_last_o,
  output logic [15:0] out_length_o
);

  logic [15:0]   bs_q;
  logic          unix_q;
  logic          push, pop, full, empty;
  fsf_pkg::cmd_t cmd_in, cmd_out;

  // configuration registers
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'd0, unix_q} : {16'd0, bs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= 16'd256;
      unix_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) unix_q <= pwdata[0];
      else          bs_q   <= pwdata[15:0];
    end
  end

  fsf_front #(.WidthCap(WidthCap)) u_front (
    .clk_i, .rst_ni,
    .unix_i   (unix_q),
    .valid_i  (in_valid_i),
    .action_i,
    .ch_i,
    .arg_i,
    .full_i   (full),
    .stall_o  (in_stall_o),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  fsf_cmdq u_cmdq (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  fsf_back u_back (
    .clk_i, .rst_ni,
    .buf_size_i (bs_q),
    .empty_i    (empty),
    .cmd_i      (cmd_out),
    .pop_o      (pop),
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .out_last_o,
    .out_length_o
  );

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Format string formatter testbench
// Drives format, string-argument and end beats and checks every output
// character against an in-bench printf predictor, across several buffer
// sizes and line-ending modes, with random idling and a long output hold.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [2:0] ADDR_BUF_SIZE = 3'd0;
  localparam logic [2:0] ADDR_LINE_END = 3'd4;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [15:0] length;
  } char_beat_t;

  typedef struct {
    fsf_pkg::act_e act;
    logic [7:0]    ch;
    logic [31:0]   arg;
    bit            fixed;
    logic [7:0]    fixed_ch;
    logic [15:0]   fixed_len;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [7:0]  ch_i = '0;
  logic [31:0] arg_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        out_last_o;
  logic [15:0] out_length_o;

  format_string_formatter_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and configuration
  int unsigned   buf_size = 256;
  bit            unix_lf = 1'b1;
  int            mode = 0;       // 0 text, 1 conversion, 2 string argument
  fsf_pkg::pad_e pad = fsf_pkg::PK_NONE;
  int            fwidth = -1;
  int unsigned   kept = 0;

  char_beat_t  expected_chars[$];
  char_beat_t  item_chars[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          chars_seen = 0;
  int          cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;

  // Keep one character if the buffer still has room
  function automatic void put_char(int unsigned c);
    int unsigned cap;
    cap = (buf_size == 0) ? 0 : buf_size - 1;
    if (kept < cap && item_chars.size() < 64) begin
      kept++;
      item_chars.push_back('{c[7:0], 1'b0, kept[15:0]});
    end
  endfunction

  function automatic void put_decimal(int unsigned v, fsf_pkg::pad_e pk, int w);
    int unsigned div, rem;
    bit seen;
    int left, n;
    div = 999999999; rem = v; seen = 0; left = 10; n = 1;
    if (w <= 0) w = 1;
    while (div >= 9) begin
      if (seen || rem > div) begin
        seen = 1;
        put_char(rem / (div + 1) + fsf_pkg::CH_0);
        n++;
      end else if (left <= w && pk != fsf_pkg::PK_AFTER) begin
        put_char(pk == fsf_pkg::PK_ZERO ? fsf_pkg::CH_0 : fsf_pkg::CH_SP);
        n++;
      end
      left--;
      rem = rem % (div + 1);
      div = div / 10;
    end
    put_char(rem + fsf_pkg::CH_0);
    if (pk == fsf_pkg::PK_AFTER)
      for (int k = w - n; k > 0; k--) put_char(fsf_pkg::CH_SP);
  endfunction

  // Hex quirk: padding only replaces leading zero nibbles, left-justify doubles width
  function automatic void put_hex_digits(logic [31:0] v, fsf_pkg::pad_e pk, int w);
    bit seen;
    int left, n;
    logic [3:0] nib;
    seen = 0; left = 8; n = 0;
    for (int pos = 8; pos > 0; pos--) begin
      nib = v[(pos-1)*4 +: 4];
      if (nib != 0 || seen || pos == 1) begin
        seen = 1;
        put_char(nib + (nib > 9 ? fsf_pkg::HEX_ALPHA_OFS : fsf_pkg::CH_0));
        n++;
      end else begin
        if (left <= w) begin
          if (pk == fsf_pkg::PK_ZERO) put_char(fsf_pkg::CH_0);
          else if (pk == fsf_pkg::PK_SPACE) put_char(fsf_pkg::CH_SP);
        end
        left--;
      end
    end
    if (pk == fsf_pkg::PK_AFTER)
      for (int k = w * 2 - n; k > 0; k--) put_char(fsf_pkg::CH_SP);
  endfunction

  function automatic void conversion_char(logic [7:0] c, logic [31:0] arg);
    logic [31:0] v;
    int w;
    if (c == fsf_pkg::CH_MINUS) begin
      pad = fsf_pkg::PK_AFTER;
      return;
    end
    if (c == fsf_pkg::CH_0 && fwidth < 0 && pad == fsf_pkg::PK_NONE) begin
      pad = fsf_pkg::PK_ZERO;
      return;
    end
    if (c >= fsf_pkg::CH_0 && c <= fsf_pkg::CH_9) begin
      fwidth = (fwidth < 0) ? int'(c - fsf_pkg::CH_0)
                            : 10 * fwidth + int'(c - fsf_pkg::CH_0);
      if (fwidth > 31) fwidth = 31;
      if (pad == fsf_pkg::PK_NONE) pad = fsf_pkg::PK_SPACE;
      return;
    end
    if (c == fsf_pkg::CH_L || c == fsf_pkg::CH_H || c == fsf_pkg::CH_Z) return;
    mode = 0;
    if (c == fsf_pkg::CH_D || c == fsf_pkg::CH_I) begin
      v = arg; w = fwidth;
      if (v[31]) begin
        put_char(fsf_pkg::CH_MINUS);
        v = -v;
        w--;
      end
      put_decimal(v, pad, w);
    end else if (c == fsf_pkg::CH_U) put_decimal(arg, pad, fwidth);
    else if (c == fsf_pkg::CH_P) begin
      put_char(fsf_pkg::CH_0);
      put_char(fsf_pkg::CH_X);
      put_hex_digits(arg, fsf_pkg::PK_ZERO, 8);
    end else if (c == fsf_pkg::CH_X || c == fsf_pkg::CH_XU) put_hex_digits(arg, pad, fwidth);
    else if (c == fsf_pkg::CH_S) mode = 2;
    else if (c == fsf_pkg::CH_C) put_char(arg[7:0]);
    else if (c == fsf_pkg::CH_PCT) put_char(fsf_pkg::CH_PCT);
    else begin
      put_char(fsf_pkg::CH_PCT);
      put_char(c);
    end
  endfunction

  // Work out the characters one accepted beat produces
  function automatic void format_beat(fsf_pkg::act_e act, logic [7:0] c, logic [31:0] arg);
    item_chars.delete();
    case (act)
      fsf_pkg::ACT_FMT: begin
        if (c != fsf_pkg::CH_NUL) begin
          if (mode == 2) mode = 0;
          if (mode == 0) begin
            if (c == fsf_pkg::CH_PCT) begin
              mode = 1; pad = fsf_pkg::PK_NONE; fwidth = -1;
            end else begin
              if (!unix_lf && c == fsf_pkg::CH_LF) put_char(fsf_pkg::CH_CR);
              put_char(c);
            end
          end else conversion_char(c, arg);
        end
      end
      fsf_pkg::ACT_STR: begin
        if (mode == 2) begin
          if (c == fsf_pkg::CH_NUL) mode = 0;
          else put_char(c);
        end
      end
      fsf_pkg::ACT_END: begin
        item_chars.push_back('{fsf_pkg::CH_NUL, 1'b0, kept[15:0]});
        mode = 0; pad = fsf_pkg::PK_NONE; fwidth = -1; kept = 0;
      end
      default: ;
    endcase
    if (item_chars.size() > 0) item_chars[item_chars.size()-1].last = 1'b1;
  endfunction

  // Offer one beat, hold it until accepted, then predict
  task automatic send_beat(fsf_pkg::act_e act, logic [7:0] c, logic [31:0] arg,
                           bit fixed = 0, logic [7:0] fch = 0, logic [15:0] flen = 0);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1; action_i = act; ch_i = c; arg_i = arg;
    do @(posedge clk_i); while (in_stall_o);
    format_beat(act, c, arg);
    if (fixed) begin
      item_chars.delete();
      item_chars.push_back('{fch, 1'b1, flen});
    end
    foreach (item_chars[i]) expected_chars.push_back(item_chars[i]);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_BUF_SIZE) buf_size = data[15:0];
    else unix_lf = data[0];
  endtask

  task automatic drain;
    wait (expected_chars.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_arg;
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 99);
      default: return $urandom;
    endcase
  endfunction

  // One random burst of beats: mostly well-formed conversions and text
  task automatic random_sequence;
    logic [7:0] convs[10];
    int n;
    convs = '{fsf_pkg::CH_D, fsf_pkg::CH_I, fsf_pkg::CH_U, fsf_pkg::CH_X, fsf_pkg::CH_XU,
              fsf_pkg::CH_P, fsf_pkg::CH_C, fsf_pkg::CH_S, fsf_pkg::CH_PCT, 8'h71};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_beat(fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, $urandom);
        case ($urandom_range(0, 3))
          0: send_beat(fsf_pkg::ACT_FMT, fsf_pkg::CH_MINUS, $urandom);
          1: send_beat(fsf_pkg::ACT_FMT, fsf_pkg::CH_0, $urandom);
          default: ;
        endcase
        n = $urandom_range(0, 2);
        repeat (n)
          send_beat(fsf_pkg::ACT_FMT, 8'(fsf_pkg::CH_0 + $urandom_range(0, 9)), $urandom);
        if ($urandom_range(0, 4) == 0) send_beat(fsf_pkg::ACT_FMT, fsf_pkg::CH_L, $urandom);
        send_beat(fsf_pkg::ACT_FMT, convs[$urandom_range(0, 9)], pick_arg());
        if (mode == 2) begin
          n = $urandom_range(0, 6);
          repeat (n) send_beat(fsf_pkg::ACT_STR, 8'($urandom_range(1, 255)), $urandom);
          if ($urandom_range(0, 2) != 0)
            send_beat(fsf_pkg::ACT_STR, fsf_pkg::CH_NUL, $urandom);
        end
      end
      4, 5, 6: begin
        n = $urandom_range(1, 3);
        repeat (n)
          send_beat(fsf_pkg::ACT_FMT,
                    ($urandom_range(0, 3) == 0) ? fsf_pkg::CH_LF
                                                : 8'($urandom_range(1, 255)),
                    $urandom);
      end
      7: send_beat(fsf_pkg::ACT_END, 8'($urandom), $urandom);
      default: send_beat(fsf_pkg::act_e'($urandom_range(0, 3)), 8'($urandom), $urandom);
    endcase
  endtask

  // Output side: random stall bursts plus one long hold on request
  always @(negedge clk_i) begin
    static int burst = 0;
    static int hold = 0;
    static bit hold_done = 0;
    if (hold_req && !hold_done) begin
      hold = 300;
      hold_done = 1;
    end
    if (hold > 0) begin
      hold--;
      out_stall_i <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  // Compare each accepted character beat with the oldest expectation
  always @(posedge clk_i) begin
    char_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected output beat: char %h last %b length %0d",
               out_char_o, out_last_o, out_length_o);
        fail_count++;
      end else begin
        exp_beat = expected_chars.pop_front();
        if (out_char_o !== exp_beat.ch) begin
          $error("out_char: expected %h, actual %h", exp_beat.ch, out_char_o);
          fail_count++;
        end
        if (out_last_o !== exp_beat.last) begin
          $error("last: expected %b, actual %b", exp_beat.last, out_last_o);
          fail_count++;
        end
        if (out_length_o !== exp_beat.length) begin
          $error("length: expected %0d, actual %0d", exp_beat.length, out_length_o);
          fail_count++;
        end
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d characters outstanding", expected_chars.size());
      $display("** format_string_formatter_top: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    int unsigned sizes[5];
    bit lfs[5];
    sizes = '{0, 1, 65535, 12, 256};
    lfs = '{0, 1, 0, 1, 0};

    rows.push_back('{fsf_pkg::ACT_END, 8'h00, 32'h0, 1, fsf_pkg::CH_NUL, 16'd0});
    rows.push_back('{fsf_pkg::ACT_FMT, 8'h41, 32'h0, 1, 8'h41, 16'd1});
    rows.push_back('{fsf_pkg::ACT_FMT, 8'hff, 32'hffff_ffff, 1, 8'hff, 16'd2});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_D, 32'h8000_0000, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_0, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, 8'h35, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_X, 32'h1f, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_MINUS, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_9, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_9, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_XU, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_U, 32'hffff_ffff, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_P, 32'h00ab_0000, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_H, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_C, 32'h1234_5641, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, 8'h71, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_PCT, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_S, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_STR, 8'h68, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_STR, fsf_pkg::CH_NUL, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_STR, 8'h68, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_NUL, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_NONE, 8'h55, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_FMT, fsf_pkg::CH_LF, 32'h0, 0, 0, 0});
    rows.push_back('{fsf_pkg::ACT_END, 8'h00, 32'h0, 0, 0, 0});

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table under the reset configuration
    foreach (rows[i])
      send_beat(rows[i].act, rows[i].ch, rows[i].arg,
                rows[i].fixed, rows[i].fixed_ch, rows[i].fixed_len);

    // Random phases, one per register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      reg_write(ADDR_BUF_SIZE, sizes[ph]);
      reg_write(ADDR_LINE_END, 32'(lfs[ph]));
      if (ph == 4) idle_en = 1'b0;
      if (ph == 2) hold_req = 1'b1;
      for (int n = items_sent + 15; items_sent < n;) random_sequence();
      send_beat(fsf_pkg::ACT_END, 8'h00, 32'h0);
    end

    drain();
    $display("run covered %0d beats and %0d output characters", items_sent, chars_seen);
    $display("buffer sizes 0, 1, 12, 256 and 65535 with both line-ending modes");
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("** format_string_formatter_top: PASSED **");
    end else begin
      $display("** format_string_formatter_top: FAILED **");
    end
    $finish;
  end

endmodule
